// ===== design/efws_pkg.sv =====
`timescale 1ns / 1ps

package efws_pkg;

	localparam int DUR_W = 32;
	localparam int CFG_W = 5;
	localparam int ID_OUT_W = 4;
	localparam int WORKER_COUNT_RESET = 16;

	typedef struct packed {
		logic load;
		logic scan;
		logic update;
		logic clear;
	} efws_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic clear_done;
	} efws_status_t;

endpackage

// ===== design/efws_ram.sv =====
`timescale 1ns / 1ps

module efws_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/efws_ctrl.sv =====
`timescale 1ns / 1ps

module efws_ctrl
	import efws_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         cfg_we,
	input  efws_status_t status,
	output efws_cmd_t    cmd,
	output logic         busy
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else if (cfg_we) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (status.clear_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.scan_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.update = (state_q == ST_UPDATE);
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== design/efws_datapath.sv =====
`timescale 1ns / 1ps

module efws_datapath
	import efws_pkg::*;
#(
	parameter int MAX_WORKERS = 16,
	parameter int TIME_WIDTH = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_data,
	input  efws_cmd_t             cmd,
	output efws_status_t          status,
	input  logic [DUR_W-1:0]      duration,
	output logic                  done,
	output logic [ID_OUT_W-1:0]   worker_id,
	output logic [TIME_WIDTH-1:0] start_time,
	output logic                  overflow
);

	localparam int IDX_W = $clog2(MAX_WORKERS);
	localparam int CNT_W = $clog2(MAX_WORKERS + 1);
	localparam int COUNT_RESET =
		(WORKER_COUNT_RESET > MAX_WORKERS) ? MAX_WORKERS : WORKER_COUNT_RESET;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  rvalid_q;
	logic [IDX_W-1:0]      ridx_q;
	logic [DUR_W-1:0]      dur_q;
	logic [IDX_W-1:0]      best_id_q;
	logic [TIME_WIDTH-1:0] best_time_q;
	logic                  done_q;
	logic [ID_OUT_W-1:0]   worker_id_q;
	logic [TIME_WIDTH-1:0] start_time_q;
	logic                  overflow_q;

	logic [CNT_W-1:0]      count_new;
	logic [CNT_W-1:0]      last_idx;
	logic                  issue;
	logic [TIME_WIDTH-1:0] rdata;
	logic [TIME_WIDTH:0]   sum;
	logic [TIME_WIDTH-1:0] new_time;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [TIME_WIDTH-1:0] ram_wdata;

	// A written count of zero means one worker; larger values clamp to the pool size.
	always_comb begin
		if (cfg_data == '0) begin
			count_new = CNT_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_WORKERS)) begin
			count_new = CNT_W'(MAX_WORKERS);
		end else begin
			count_new = CNT_W'(cfg_data);
		end
	end

	assign last_idx = count_q - CNT_W'(1);
	assign issue    = cmd.scan && (cnt_q < count_q);

	assign status.clear_done = cmd.clear && (cnt_q == last_idx);
	assign status.scan_done  = rvalid_q && (CNT_W'(ridx_q) == last_idx);

	assign sum      = {1'b0, best_time_q} + (TIME_WIDTH + 1)'(dur_q);
	assign new_time = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = best_id_q;
		ram_wdata = new_time;
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q[IDX_W-1:0];
			ram_wdata = '0;
		end else if (cmd.update) begin
			ram_we = 1'b1;
		end
	end

	efws_ram #(
		.WIDTH(TIME_WIDTH),
		.DEPTH(MAX_WORKERS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= CNT_W'(COUNT_RESET);
			cnt_q    <= '0;
			rvalid_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cfg_we) begin
				count_q <= count_new;
			end
			if (cfg_we || cmd.load) begin
				cnt_q    <= '0;
				rvalid_q <= 1'b0;
			end else begin
				if (cmd.clear || issue) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				rvalid_q <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dur_q <= duration;
		end
		if (issue) begin
			ridx_q <= cnt_q[IDX_W-1:0];
		end
		if (rvalid_q && ((ridx_q == '0) || (rdata < best_time_q))) begin
			best_id_q   <= ridx_q;
			best_time_q <= rdata;
		end
		if (cmd.update) begin
			worker_id_q  <= ID_OUT_W'(best_id_q);
			start_time_q <= best_time_q;
			overflow_q   <= sum[TIME_WIDTH];
		end
	end

	assign done       = done_q;
	assign worker_id  = worker_id_q;
	assign start_time = start_time_q;
	assign overflow   = overflow_q;

endmodule

// ===== design/earliest_free_worker_scheduler_core.sv =====
// A job taken on start scans the finish-time memory one worker per cycle, then updates the
// earliest free worker's finish time; a new job is taken only after the last one's update.
// Results cannot be stalled; done is high for exactly one cycle per job.
// After reset, and after each worker count write, busy stays high while the finish times
// are cleared to zero. Reset selects sixteen workers, clamped to MAX_WORKERS.
// A worker count write is taken only while no job is in flight, and busy is high while it is offered.
`timescale 1ns / 1ps

module earliest_free_worker_scheduler_core
	import efws_pkg::*;
#(
	parameter int MAX_WORKERS = 16,
	parameter int TIME_WIDTH = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [DUR_W-1:0]      duration,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data,
	output logic                  done,
	output logic [ID_OUT_W-1:0]   worker_id,
	output logic [TIME_WIDTH-1:0] start_time,
	output logic                  overflow
);

	efws_cmd_t    cmd;
	efws_status_t status;
	logic         cfg_we;
	logic         ctrl_busy;

	assign cfg_ready = !ctrl_busy;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign busy      = ctrl_busy || cfg_valid;

	efws_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cfg_we(cfg_we),
		.status(status),
		.cmd   (cmd),
		.busy  (ctrl_busy)
	);

	efws_datapath #(
		.MAX_WORKERS(MAX_WORKERS),
		.TIME_WIDTH (TIME_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.duration  (duration),
		.done      (done),
		.worker_id (worker_id),
		.start_time(start_time),
		.overflow  (overflow)
	);

endmodule
